// File: hdl/pbbm_pkg.sv
// Shared types and constants for the packed bitfield bank memory.
package pbbm_pkg;

  localparam int GLOBAL_BANKS_DEF   = 8;
  localparam int WORDS_PER_BANK_DEF = 2000;
  localparam int QUEUE_DEPTH        = 2;

  // Address field wide enough for the largest legal store (9 banks of 2048 words).
  localparam int STORE_ADDR_W = 15;

  localparam logic       ACT_READ   = 1'b0;
  localparam logic       ACT_WRITE  = 1'b1;
  localparam logic [3:0] LOCAL_BANK = 4'd8;
  localparam logic [2:0] WC_WORD    = 3'd0;
  localparam logic [2:0] WC_BIT1    = 3'd1;
  localparam logic [2:0] WC_BIT2    = 3'd2;
  localparam logic [2:0] WC_BIT4    = 3'd3;
  localparam logic [2:0] WC_BIT8    = 3'd4;
  localparam logic [2:0] WC_BIT16   = 3'd5;

  typedef struct packed {
    logic                    err;
    logic                    write;
    logic [STORE_ADDR_W-1:0] addr;
    logic [4:0]              bit_shift;
    logic [31:0]             bit_mask;
    logic [31:0]             wdata;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        access_error;
  } res_t;

endpackage

// File: hdl/packed_bitfield_bank_memory_unit.sv
// Top level of the packed bitfield bank memory: front end, command queue, back end, result queue.
// The single memory port is used read then write: a word is read, then updated for writes.
// A new item is popped only after the last result is pushed and while the result queue has room.
// Reset: rst_n is synchronous, active low; afterwards a clearing pass zeroes the store one word a
// cycle, (GLOBAL_BANKS+1)*WORDS_PER_BANK words (18000 by default), while in_full stays high.
module packed_bitfield_bank_memory_unit
  import pbbm_pkg::*;
#(
  parameter int GLOBAL_BANKS   = GLOBAL_BANKS_DEF,
  parameter int WORDS_PER_BANK = WORDS_PER_BANK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic [3:0]         in_bank_select,
  input  logic [2:0]         in_width_code,
  input  logic [15:0]        in_location,
  input  logic signed [31:0] in_write_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_read_value,
  output logic               out_access_error
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_full, cmd_empty, cmd_pop;
  logic clearing;
  logic res_push, res_full;

  assign in_full = cmd_full || clearing;

  pbbm_front #(
    .GLOBAL_BANKS  (GLOBAL_BANKS),
    .WORDS_PER_BANK(WORDS_PER_BANK)
  ) u_front (
    .in_action     (in_action),
    .in_bank_select(in_bank_select),
    .in_width_code (in_width_code),
    .in_location   (in_location),
    .in_write_value(in_write_value),
    .cmd           (cmd_in)
  );

  pbbm_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push && !clearing),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  pbbm_back #(
    .GLOBAL_BANKS  (GLOBAL_BANKS),
    .WORDS_PER_BANK(WORDS_PER_BANK)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_head (cmd_head),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .clearing (clearing),
    .res      (res_in),
    .res_push (res_push),
    .res_full (res_full)
  );

  pbbm_queue #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_head),
    .empty(out_empty)
  );

  assign out_read_value   = res_head.read_value;
  assign out_access_error = res_head.access_error;

endmodule

// File: hdl/pbbm_queue.sv
// Small first-in first-out queue built from flip-flops.
module pbbm_queue
  import pbbm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/pbbm_front.sv
// Front end: checks bank, width and location, and forms the word address and element mask.
module pbbm_front
  import pbbm_pkg::*;
#(
  parameter int GLOBAL_BANKS   = GLOBAL_BANKS_DEF,
  parameter int WORDS_PER_BANK = WORDS_PER_BANK_DEF
) (
  input  logic        in_action,
  input  logic [3:0]  in_bank_select,
  input  logic [2:0]  in_width_code,
  input  logic [15:0] in_location,
  input  logic [31:0] in_write_value,
  output cmd_t        cmd
);

  logic        bank_ok;
  logic [3:0]  slot;
  logic        code_ok;
  logic [2:0]  idx_shift;
  logic [2:0]  ew_log;
  logic [15:0] word_idx;
  logic [15:0] offset;
  logic        loc_ok;
  logic [31:0] elem_mask;
  logic [4:0]  bit_shift;

  always_comb begin
    bank_ok = (in_bank_select == LOCAL_BANK) || (in_bank_select < 4'(GLOBAL_BANKS));
    slot    = (in_bank_select == LOCAL_BANK) ? 4'(GLOBAL_BANKS) : in_bank_select;
    code_ok = (in_width_code <= WC_BIT16);

    // Element of width 2^(k-1) packs 2^(6-k) to a word.
    unique case (in_width_code)
      WC_WORD:  begin idx_shift = 3'd0; ew_log = 3'd0; elem_mask = 32'hFFFF_FFFF; end
      WC_BIT1:  begin idx_shift = 3'd5; ew_log = 3'd0; elem_mask = 32'h0000_0001; end
      WC_BIT2:  begin idx_shift = 3'd4; ew_log = 3'd1; elem_mask = 32'h0000_0003; end
      WC_BIT4:  begin idx_shift = 3'd3; ew_log = 3'd2; elem_mask = 32'h0000_000F; end
      WC_BIT8:  begin idx_shift = 3'd2; ew_log = 3'd3; elem_mask = 32'h0000_00FF; end
      WC_BIT16: begin idx_shift = 3'd1; ew_log = 3'd4; elem_mask = 32'h0000_FFFF; end
      default:  begin idx_shift = 3'd0; ew_log = 3'd0; elem_mask = 32'h0000_0000; end
    endcase

    word_idx  = in_location >> idx_shift;
    offset    = in_location & ((16'd1 << idx_shift) - 16'd1);
    bit_shift = 5'(offset[4:0] << ew_log);
    loc_ok    = (word_idx < 16'(WORDS_PER_BANK));

    cmd.err       = !(bank_ok && code_ok && loc_ok);
    cmd.write     = (in_action == ACT_WRITE);
    cmd.addr      = STORE_ADDR_W'(slot) * STORE_ADDR_W'(WORDS_PER_BANK)
                  + word_idx[STORE_ADDR_W-1:0];
    cmd.bit_shift = bit_shift;
    cmd.bit_mask  = elem_mask << bit_shift;
    cmd.wdata     = (in_write_value & elem_mask) << bit_shift;
  end

endmodule

// File: hdl/pbbm_back.sv
// Back end: clears the store after reset, then reads and, for writes, updates one word per item.
module pbbm_back
  import pbbm_pkg::*;
#(
  parameter int GLOBAL_BANKS   = GLOBAL_BANKS_DEF,
  parameter int WORDS_PER_BANK = WORDS_PER_BANK_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd_head,
  input  logic cmd_empty,
  output logic cmd_pop,
  output logic clearing,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  localparam int DEPTH  = (GLOBAL_BANKS + 1) * WORDS_PER_BANK;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_ACCESS = 3'b100
  } state_t;

  logic [31:0]       mem [DEPTH];
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  cmd_t              cmd_r;
  logic [31:0]       rdata_r;
  logic              rd_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [31:0]       new_word;
  logic [31:0]       elem_val;

  assign clearing = (state_r == S_CLEAR);
  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty && !res_full;
  assign rd_en    = cmd_pop && !cmd_head.err;
  assign res_push = (state_r == S_ACCESS);

  always_comb begin
    new_word = (rdata_r & ~cmd_r.bit_mask) | cmd_r.wdata;
    elem_val = (rdata_r & cmd_r.bit_mask) >> cmd_r.bit_shift;

    res.access_error = cmd_r.err;
    res.read_value   = (cmd_r.err || cmd_r.write) ? 32'd0 : elem_val;

    mem_we    = 1'b0;
    mem_waddr = cmd_r.addr[ADDR_W-1:0];
    mem_wdata = new_word;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 32'd0;
    end else if (state_r == S_ACCESS) begin
      mem_we = cmd_r.write && !cmd_r.err;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_pop) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[cmd_head.addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // No item may be taken from the command queue while the store is being cleared.
  a_no_pop_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cmd_pop)
    else $error("command popped during clearing pass");

  // A rejected access must never modify the store.
  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_ACCESS) |-> (cmd_r.write && !cmd_r.err))
    else $error("store written by a rejected or read access");

  // Every popped item produces its result on the following cycle.
  a_pop_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> res_push)
    else $error("popped item produced no result");

  // The result queue always has room when a result is pushed.
  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule
